[rtl/assert_macros.svh]
// assertion macros shared by the framer rtl
// expects signals named clk and rst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define SLPF_ASSERT_IMPL(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define SLPF_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

[rtl/slpf_pkg.sv]
// types, constants and defaults for the sync and length prefix framer
// no dependencies
`timescale 1ns / 1ps

package slpf_pkg;

  // parameter defaults
  localparam int FRAME_PAYLOAD_DEF = 32;
  localparam int MAX_MESSAGE_DEF   = 4096;

  // fixed field widths
  localparam int DATA_W  = 8;
  localparam int LEN_W   = 13;
  localparam int FLEN_W  = 7;   // frame length never above 99
  localparam int DIGIT_W = 4;
  localparam int STEP_W  = 3;   // up to seven characters per transaction

  // header characters
  localparam logic [DATA_W-1:0] SYNC_CHAR  = 8'h32;
  localparam int                SYNC_COUNT = 4;
  localparam logic [DATA_W-1:0] DIGIT_ZERO = 8'h30;
  localparam int                DIGIT_BASE = 10;

  // input transaction
  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic [LEN_W-1:0]  message_length;
  } in_item_t;

  // output transaction
  typedef struct packed {
    logic [DATA_W-1:0] out_char;
    logic              run_last;
  } out_item_t;

  // one decoded byte handed to the serializer
  typedef struct packed {
    logic [DATA_W-1:0]  data_byte;
    logic               hdr;
    logic               two_digit;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] ones;
  } frame_job_t;

endpackage

[rtl/sync_length_prefix_framer.sv]
// Sync and length prefix framer. Takes one message byte per input
// transaction, tagged with the message's total length, and cuts the message
// into frames of up to FRAME_PAYLOAD bytes. The first byte of each frame
// goes out after four '2' sync characters and the frame length in ASCII
// decimal; other bytes pass through as one character. The serializer emits
// one character per cycle unless out_stall holds it; a pass-through byte is
// one character and a frame-start byte 6 or 7 (one or two length digits); a
// full frame of 32 bytes costs 38 characters. Input is registered and decoded
// in one pass, so the next byte is accepted while the current characters are
// still going out. No clearing pass after reset: the block can take input at once.
// depends on slpf_pkg, slpf_hdr and slpf_ser
`timescale 1ns / 1ps

module sync_length_prefix_framer #(
  parameter int FRAME_PAYLOAD = slpf_pkg::FRAME_PAYLOAD_DEF,
  parameter int MAX_MESSAGE   = slpf_pkg::MAX_MESSAGE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  slpf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output slpf_pkg::out_item_t out_data
);

  logic                 job_valid;
  logic                 job_take;
  slpf_pkg::frame_job_t job;

  // decode stage
  slpf_hdr #(
    .FRAME_PAYLOAD (FRAME_PAYLOAD),
    .MAX_MESSAGE   (MAX_MESSAGE)
  ) u_hdr (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job_take  (job_take),
    .job       (job)
  );

  // output stage
  slpf_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_take  (job_take),
    .job       (job),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/slpf_hdr.sv]
// input register, message position tracking and frame header decode
// depends on slpf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slpf_hdr #(
  parameter int FRAME_PAYLOAD = slpf_pkg::FRAME_PAYLOAD_DEF,
  parameter int MAX_MESSAGE   = slpf_pkg::MAX_MESSAGE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  slpf_pkg::in_item_t   in_data,
  output logic                 job_valid,
  input  logic                 job_take,
  output slpf_pkg::frame_job_t job
);

  localparam int PW  = (MAX_MESSAGE > 1) ? $clog2(MAX_MESSAGE) : 1;
  localparam int LW  = ($clog2(MAX_MESSAGE + 1) > slpf_pkg::LEN_W) ?
                       $clog2(MAX_MESSAGE + 1) : slpf_pkg::LEN_W;
  localparam int FCW = (FRAME_PAYLOAD > 1) ? $clog2(FRAME_PAYLOAD) : 1;

  logic               in_valid_r;
  slpf_pkg::in_item_t in_data_r;
  logic [PW-1:0]      pos_r;
  logic [PW-1:0]      pos_nxt;
  logic [FCW-1:0]     fpos_r;
  logic [FCW-1:0]     fpos_nxt;

  logic [LW-1:0]      len_raw;
  logic [LW-1:0]      len_c;
  logic [PW-1:0]      pos_eff;
  logic [FCW-1:0]     fpos_eff;
  logic [LW-1:0]      pos_inc;
  logic [FCW:0]       fpos_inc;
  logic [LW-1:0]      rem_c;
  logic [LW-1:0]      flen_w;
  logic [slpf_pkg::FLEN_W-1:0]  flen_c;
  logic [slpf_pkg::FLEN_W-1:0]  ones_w;
  logic [slpf_pkg::DIGIT_W-1:0] tens_c;

  // input register, freed when the serializer takes the transaction
  assign in_stall  = in_valid_r && !job_take;
  assign job_valid = in_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  // clamp length and restart when position runs past it
  always_comb begin
    len_raw = LW'(in_data_r.message_length);
    if (len_raw == '0) begin
      len_c = LW'(1);
    end else if (len_raw > LW'(MAX_MESSAGE)) begin
      len_c = LW'(MAX_MESSAGE);
    end else begin
      len_c = len_raw;
    end
    if (LW'(pos_r) >= len_c) begin
      pos_eff  = '0;
      fpos_eff = '0;
    end else begin
      pos_eff  = pos_r;
      fpos_eff = fpos_r;
    end
  end

  // frame length and its decimal digits
  always_comb begin
    rem_c  = len_c - LW'(pos_eff);
    flen_w = (rem_c < LW'(FRAME_PAYLOAD)) ? rem_c : LW'(FRAME_PAYLOAD);
    flen_c = flen_w[slpf_pkg::FLEN_W-1:0];
    tens_c = '0;
    for (int i = 1; i <= 9; i++) begin
      if (flen_c >= slpf_pkg::FLEN_W'(i * slpf_pkg::DIGIT_BASE)) begin
        tens_c = slpf_pkg::DIGIT_W'(i);
      end
    end
    ones_w = flen_c - slpf_pkg::FLEN_W'(slpf_pkg::FLEN_W'(tens_c) *
                                         slpf_pkg::FLEN_W'(slpf_pkg::DIGIT_BASE));
  end

  assign job.data_byte = in_data_r.data_byte;
  assign job.hdr       = (fpos_eff == '0);
  assign job.two_digit = (tens_c != '0);
  assign job.tens      = tens_c;
  assign job.ones      = ones_w[slpf_pkg::DIGIT_W-1:0];

  // next message and frame position
  always_comb begin
    pos_inc  = LW'(pos_eff) + LW'(1);
    fpos_inc = {1'b0, fpos_eff} + {{FCW{1'b0}}, 1'b1};
    if (pos_inc >= len_c) begin
      pos_nxt  = '0;
      fpos_nxt = '0;
    end else begin
      pos_nxt  = pos_inc[PW-1:0];
      fpos_nxt = (fpos_inc == (FCW+1)'(FRAME_PAYLOAD)) ? '0 : fpos_inc[FCW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fpos_r <= '0;
    end else if (job_take) begin
      pos_r  <= pos_nxt;
      fpos_r <= fpos_nxt;
    end
  end

  // checks
  `SLPF_ASSERT_IMPL(a_frame_aligned, pos_r == '0, fpos_r == '0,
                    "frame position off at message start")
  `SLPF_ASSERT_NEXT(a_stall_holds, in_valid_r && in_stall,
                    in_valid_r && $stable(pos_r) && $stable(fpos_r),
                    "position moved while transaction held")

endmodule

[rtl/slpf_ser.sv]
// character serializer: sync characters and length digits before a frame's first byte, then payload byte
// depends on slpf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slpf_ser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  output logic                 job_take,
  input  slpf_pkg::frame_job_t job,
  output logic                 out_valid,
  input  logic                 out_stall,
  output slpf_pkg::out_item_t  out_data
);

  logic                         job_valid_r;
  slpf_pkg::frame_job_t         job_r;
  logic [slpf_pkg::STEP_W-1:0]  step_r;
  logic [slpf_pkg::STEP_W-1:0]  last_step_c;
  logic                         last_c;
  logic                         out_fire;
  logic                         load_ok;
  logic [slpf_pkg::DATA_W-1:0]  char_c;

  // step index of the last character of the held transaction
  always_comb begin
    if (!job_r.hdr) begin
      last_step_c = '0;
    end else if (job_r.two_digit) begin
      last_step_c = slpf_pkg::STEP_W'(slpf_pkg::SYNC_COUNT + 2);
    end else begin
      last_step_c = slpf_pkg::STEP_W'(slpf_pkg::SYNC_COUNT + 1);
    end
  end

  assign last_c   = (step_r == last_step_c);
  assign out_fire = job_valid_r && !out_stall;
  assign load_ok  = !job_valid_r || (out_fire && last_c);
  assign job_take = job_valid && load_ok;

  // character select
  always_comb begin
    priority if (!job_r.hdr) begin
      char_c = job_r.data_byte;
    end else if (step_r < slpf_pkg::STEP_W'(slpf_pkg::SYNC_COUNT)) begin
      char_c = slpf_pkg::SYNC_CHAR;
    end else if (step_r == slpf_pkg::STEP_W'(slpf_pkg::SYNC_COUNT)) begin
      char_c = slpf_pkg::DIGIT_ZERO + slpf_pkg::DATA_W'(job_r.two_digit ? job_r.tens
                                                                          : job_r.ones);
    end else if (job_r.two_digit &&
                 step_r == slpf_pkg::STEP_W'(slpf_pkg::SYNC_COUNT + 1)) begin
      char_c = slpf_pkg::DIGIT_ZERO + slpf_pkg::DATA_W'(job_r.ones);
    end else begin
      char_c = job_r.data_byte;
    end
  end

  assign out_valid         = job_valid_r;
  assign out_data.out_char = char_c;
  assign out_data.run_last = last_c;

  // step counter and held transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      step_r      <= '0;
    end else if (load_ok) begin
      job_valid_r <= job_valid;
      step_r      <= '0;
    end else if (out_fire) begin
      step_r <= step_r + slpf_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      job_r <= job;
    end
  end

  // checks
  `SLPF_ASSERT_NEXT(a_step_advance, out_fire && !last_c,
                    job_valid_r && step_r == $past(step_r) + 3'd1,
                    "step did not advance after a character")
  `SLPF_ASSERT_IMPL(a_step_range, job_valid_r, step_r <= last_step_c,
                    "step beyond last character")

endmodule
